// ===== rtl/core/palette_quantize_nibble_framebuffer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the palette quantizer block
// Shared property forms, clocked on clock and quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef PALETTE_QUANTIZE_NIBBLE_FRAMEBUFFER_TOP_ASSERT_SVH
`define PALETTE_QUANTIZE_NIBBLE_FRAMEBUFFER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQNF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PQNF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pqnf_pkg.sv =====
// ----------------------------------------------------------------------------
// pqnf_pkg
// Constants shared by the palette quantizer and its framebuffer store.
// ----------------------------------------------------------------------------
package pqnf_pkg;

   localparam int PANEL_WIDTH_DEF  = 1200;
   localparam int PANEL_HEIGHT_DEF = 1600;

   localparam int NUM_COLORS = 6;
   localparam int CODE_W     = 4;
   localparam int COMP_W     = 8;
   localparam int COORD_W    = 12;
   localparam int BADDR_W    = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int SQ_W       = 2 * COMP_W;
   localparam int DIST_W     = SQ_W + 2;

   localparam logic [COMP_W-1:0] COMP_MAX   = 8'd255;
   localparam logic [7:0]        CLEAR_BYTE = 8'h11;
   localparam logic [7:0]        NIB_LO     = 8'h0F;
   localparam logic [7:0]        NIB_HI     = 8'hF0;

   // Register indexes of the palette code registers.
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_BLACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_WHITE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_YELLOW = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_RED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_BLUE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_GREEN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LIMIT   = 3'd6;

   // Each palette entry has components of either 0 or 255; a set bit marks 255.
   // Bit 2 is red, bit 1 green, bit 0 blue.
   typedef logic [2:0] pal_mask_type;
   localparam pal_mask_type PALETTE_MASK [NUM_COLORS] = '{
      3'b000, 3'b111, 3'b110, 3'b100, 3'b001, 3'b010
   };

   localparam logic [CODE_W-1:0] CODE_RESET [NUM_COLORS] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6
   };

endpackage

// ===== rtl/core/pqnf_ram.sv =====
// ----------------------------------------------------------------------------
// pqnf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pqnf_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 1024,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/palette_quantize_nibble_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// palette_quantize_nibble_framebuffer_top
// Nearest-color quantizer to a six-entry palette, storing 4-bit codes in a
// nibble-packed framebuffer held in one RAM, with byte readback.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Word
//  req_    | in        | req_valid/req_ready  | kind, pos_x, pos_y, rgb, byte_addr
//  rsp_    | out       | rsp_valid/rsp_ready  | read_byte, pixel_written, color_code
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// Each word passes through accept, squares and row offset, distances and
// byte address, nearest pick with the RAM read, then the nibble write-back.
// After reset the RAM is cleared to 0x11 one byte per cycle, over all
// (PANEL_WIDTH*PANEL_HEIGHT+1)/2 bytes; req_ready stays low until then.
// A result waits in the output register while the next word is accepted; the
// write-back stage holds only if that register is still full.
// ----------------------------------------------------------------------------
module palette_quantize_nibble_framebuffer_top #(
   parameter int PANEL_WIDTH  = pqnf_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = pqnf_pkg::PANEL_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic signed [pqnf_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [pqnf_pkg::COORD_W-1:0] req_pos_y,
   input  logic [pqnf_pkg::COMP_W-1:0]     req_red,
   input  logic [pqnf_pkg::COMP_W-1:0]     req_green,
   input  logic [pqnf_pkg::COMP_W-1:0]     req_blue,
   input  logic [pqnf_pkg::BADDR_W-1:0]    req_byte_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_read_byte,
   output logic                            rsp_pixel_written,
   output logic [pqnf_pkg::CODE_W-1:0]     rsp_color_code,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pqnf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pqnf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = (PANEL_WIDTH * PANEL_HEIGHT + 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NC    = pqnf_pkg::NUM_COLORS;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_CALC  = 6'b000100,
      ST_SUM   = 6'b001000,
      ST_PICK  = 6'b010000,
      ST_WRITE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] clear_cnt_ff, clear_cnt_in;

   logic [pqnf_pkg::CODE_W-1:0] codes_ff [NC];

   logic                               kind_ff;
   logic [pqnf_pkg::COORD_W-1:0]       x_ff, y_ff;
   logic [pqnf_pkg::COMP_W-1:0]        red_ff, green_ff, blue_ff;
   logic [AW-1:0]                      baddr_ff;
   logic                               baddr_ok_ff;
   logic                               in_panel_ff;

   logic [pqnf_pkg::SQ_W-1:0] r0_ff, r1_ff, g0_ff, g1_ff, b0_ff, b1_ff;
   logic [AW:0]               row_ff;
   logic [pqnf_pkg::DIST_W-1:0] dist_ff [NC];
   logic [AW-1:0]             addr_ff;
   logic [pqnf_pkg::CODE_W-1:0] code_ff;
   logic [pqnf_pkg::CODE_W-1:0] code_in;

   logic                        rsp_valid_ff;
   logic [7:0]                  rsp_byte_ff;
   logic                        rsp_wr_ff;
   logic [pqnf_pkg::CODE_W-1:0] rsp_code_ff;

   logic [pqnf_pkg::COMP_W-1:0] ir, ig, ib;
   logic [AW:0]                 pix_sum;
   logic                        accept;
   logic                        out_free;
   logic                        advance;
   logic                        in_panel_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [7:0]    ram_rd_data;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = (state_ff == ST_WRITE) && out_free;

   assign in_panel_in = !req_pos_x[pqnf_pkg::COORD_W-1] && !req_pos_y[pqnf_pkg::COORD_W-1]
      && (req_pos_x < pqnf_pkg::COORD_W'(PANEL_WIDTH))
      && (req_pos_y < pqnf_pkg::COORD_W'(PANEL_HEIGHT));

   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + AW'(1);
            if (clear_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_PICK;
         ST_PICK:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NC; i++) begin
            codes_ff[i] <= pqnf_pkg::CODE_RESET[i];
         end
      end else if (csr_valid && csr_ready && (csr_index < pqnf_pkg::CSR_IDX_LIMIT)) begin
         codes_ff[csr_index] <= csr_wdata[pqnf_pkg::CODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_kind;
         x_ff        <= req_pos_x;
         y_ff        <= req_pos_y;
         red_ff      <= req_red;
         green_ff    <= req_green;
         blue_ff     <= req_blue;
         baddr_ff    <= AW'(req_byte_addr);
         baddr_ok_ff <= (32'(req_byte_addr) < 32'(DEPTH));
         in_panel_ff <= in_panel_in;
      end
   end

   assign ir = pqnf_pkg::COMP_MAX - red_ff;
   assign ig = pqnf_pkg::COMP_MAX - green_ff;
   assign ib = pqnf_pkg::COMP_MAX - blue_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         r0_ff  <= red_ff * red_ff;
         r1_ff  <= ir * ir;
         g0_ff  <= green_ff * green_ff;
         g1_ff  <= ig * ig;
         b0_ff  <= blue_ff * blue_ff;
         b1_ff  <= ib * ib;
         row_ff <= (AW+1)'(y_ff[pqnf_pkg::COORD_W-2:0]) * (AW+1)'(PANEL_WIDTH);
      end
   end

   assign pix_sum = row_ff + (AW+1)'(x_ff[pqnf_pkg::COORD_W-2:0]);

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         for (int i = 0; i < NC; i++) begin
            dist_ff[i] <=
               pqnf_pkg::DIST_W'(pqnf_pkg::PALETTE_MASK[i][2] ? r1_ff : r0_ff)
               + pqnf_pkg::DIST_W'(pqnf_pkg::PALETTE_MASK[i][1] ? g1_ff : g0_ff)
               + pqnf_pkg::DIST_W'(pqnf_pkg::PALETTE_MASK[i][0] ? b1_ff : b0_ff);
         end
         addr_ff <= kind_ff ? baddr_ff : pix_sum[AW:1];
      end
   end

   always_comb begin
      logic [pqnf_pkg::DIST_W-1:0] best;
      best    = '1;
      code_in = codes_ff[0];
      for (int i = 0; i < NC; i++) begin
         if (dist_ff[i] < best) begin
            best    = dist_ff[i];
            code_in = codes_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PICK) begin
         code_ff <= code_in;
      end
   end

   assign ram_rd_en = (state_ff == ST_PICK);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = ram_rd_data;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = pqnf_pkg::CLEAR_BYTE;
      end else if (advance && !kind_ff && in_panel_ff) begin
         ram_wr_en = 1'b1;
         if (!x_ff[0]) begin
            ram_wr_data = {code_ff, 4'b0000} | (ram_rd_data & pqnf_pkg::NIB_LO);
         end else begin
            ram_wr_data = (ram_rd_data & pqnf_pkg::NIB_HI) | {4'b0000, code_ff};
         end
      end
   end

   pqnf_ram #(
      .WIDTH      (8),
      .DEPTH      (DEPTH),
      .ADDR_WIDTH (AW)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff <= (kind_ff && baddr_ok_ff) ? ram_rd_data : 8'd0;
         rsp_wr_ff   <= !kind_ff && in_panel_ff;
         rsp_code_ff <= kind_ff ? '0 : code_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_byte     = rsp_byte_ff;
   assign rsp_pixel_written = rsp_wr_ff;
   assign rsp_color_code    = rsp_code_ff;

endmodule

// ===== rtl/core/pqnf_checker.sv =====
// ----------------------------------------------------------------------------
// pqnf_checker
// Port-level checks on the palette quantizer, bound to its top level.
// ----------------------------------------------------------------------------
`include "palette_quantize_nibble_framebuffer_top_assert.svh"

module pqnf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [7:0]                      rsp_read_byte,
   input logic                            rsp_pixel_written,
   input logic [pqnf_pkg::CODE_W-1:0]     rsp_color_code
);

   `PQNF_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second word taken while busy")
   `PQNF_ASSERT_NOW(a_draw_no_byte, rsp_valid && rsp_pixel_written, rsp_read_byte == 8'd0, "draw word returned a byte")
   `PQNF_ASSERT_NOW(a_read_no_code, rsp_valid && (rsp_read_byte != 8'd0), rsp_color_code == '0, "read word returned a code")
   `PQNF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_color_code) && $stable(rsp_read_byte), "stalled result changed")

endmodule

bind palette_quantize_nibble_framebuffer_top pqnf_checker u_pqnf_checker (.*);

// ===== tb/tb_palette_quantize_nibble_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// tb_palette_quantize_nibble_framebuffer_top
// Self-checking bench for the palette quantizer and its nibble framebuffer.
// A scoreboard predicts every response word: the nearest palette entry of
// each drawn pixel, the nibble it lands in and every byte read back, using a
// sparse copy of the framebuffer. Directed pixels cover two opposite panel
// corners, off-panel positions, reads past the store and every palette
// color. Random traffic mixes draws and reads in small hot corner regions
// with noise, across several palette code settings. Both channels stall in
// random bursts, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_palette_quantize_nibble_framebuffer_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PANEL_W          = pqnf_pkg::PANEL_WIDTH_DEF;
   localparam int          PANEL_H          = pqnf_pkg::PANEL_HEIGHT_DEF;
   localparam int          CW               = pqnf_pkg::COORD_W;
   localparam int          BW               = pqnf_pkg::BADDR_W;
   localparam int unsigned FRAME_BYTES      = (PANEL_W * PANEL_H + 1) / 2;
   localparam logic        KIND_DRAW        = 1'b0;
   localparam logic        KIND_READ        = 1'b1;
   localparam int          MAX_REPORTS      = 10;
   localparam int          SETTLE_CYCLES    = 8;
   localparam int          DRAIN_CYCLES     = 20;
   localparam int          LONG_HOLD_CYCLES = 400;
   localparam int          WATCHDOG_LIMIT   = 3 * FRAME_BYTES + 100000;

   localparam logic [pqnf_pkg::CSR_IDX_W-1:0] CODE_REGS [pqnf_pkg::NUM_COLORS] = '{
      pqnf_pkg::CSR_CODE_BLACK, pqnf_pkg::CSR_CODE_WHITE, pqnf_pkg::CSR_CODE_YELLOW,
      pqnf_pkg::CSR_CODE_RED, pqnf_pkg::CSR_CODE_BLUE, pqnf_pkg::CSR_CODE_GREEN
   };

   class palette_scoreboard;
      typedef struct {
         logic [7:0]                  read_byte;
         logic                        pixel_written;
         logic [pqnf_pkg::CODE_W-1:0] color_code;
      } rsp_word_type;

      logic [7:0]                  frame_mirror [int unsigned];
      logic [pqnf_pkg::CODE_W-1:0] code_reg [pqnf_pkg::NUM_COLORS];
      rsp_word_type                expected_rsp [$];
      int                          mismatches;

      function new();
         foreach (code_reg[i]) code_reg[i] = pqnf_pkg::CODE_RESET[i];
         mismatches = 0;
      endfunction

      function void set_code(logic [pqnf_pkg::CSR_IDX_W-1:0] idx,
                             logic [pqnf_pkg::CSR_DATA_W-1:0] data);
         if (idx < pqnf_pkg::CSR_IDX_LIMIT) code_reg[idx] = data[pqnf_pkg::CODE_W-1:0];
      endfunction

      function logic [7:0] stored_byte(int unsigned addr);
         return frame_mirror.exists(addr) ? frame_mirror[addr] : pqnf_pkg::CLEAR_BYTE;
      endfunction

      function void note_word(logic kind, logic signed [pqnf_pkg::COORD_W-1:0] x, y,
                              logic [pqnf_pkg::COMP_W-1:0] r, g, b,
                              logic [pqnf_pkg::BADDR_W-1:0] addr);
         rsp_word_type                w;
         int unsigned                 sq_sum, best, comp, level, idx;
         int                          pick, col, row;
         logic [7:0]                  old_byte;
         logic [pqnf_pkg::CODE_W-1:0] code;
         w.read_byte     = '0;
         w.pixel_written = 1'b0;
         w.color_code    = '0;
         if (kind == KIND_READ) begin
            if (addr < FRAME_BYTES) w.read_byte = stored_byte(32'(addr));
         end else begin
            best = 32'hFFFF_FFFF;
            pick = 1;
            for (int i = 0; i < pqnf_pkg::NUM_COLORS; i++) begin
               sq_sum = 0;
               for (int c = 0; c < 3; c++) begin
                  comp  = (c == 2) ? 32'(r) : (c == 1) ? 32'(g) : 32'(b);
                  level = pqnf_pkg::PALETTE_MASK[i][c] ? 32'(pqnf_pkg::COMP_MAX) : 0;
                  sq_sum += (comp > level) ? (comp - level) * (comp - level)
                                           : (level - comp) * (level - comp);
               end
               if (sq_sum < best) begin
                  best = sq_sum;
                  pick = i;
               end
            end
            code = code_reg[pick];
            w.color_code = code;
            col = int'(x);
            row = int'(y);
            if (col >= 0 && col < PANEL_W && row >= 0 && row < PANEL_H) begin
               idx = (row * PANEL_W + col) / 2;
               old_byte = stored_byte(idx);
               frame_mirror[idx] = col[0] ? {old_byte[7:4], code} : {code, old_byte[3:0]};
               w.pixel_written = 1'b1;
            end
         end
         expected_rsp.push_back(w);
      endfunction

      function void check_word(logic [7:0] rb, logic pw, logic [pqnf_pkg::CODE_W-1:0] cc);
         rsp_word_type w;
         if (expected_rsp.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected response word: read_byte=%h written=%b code=%h",
                        rb, pw, cc);
            mismatches++;
            return;
         end
         w = expected_rsp.pop_front();
         if (rb !== w.read_byte || pw !== w.pixel_written || cc !== w.color_code) begin
            if (mismatches < MAX_REPORTS)
               $display("response mismatch: expected read_byte=%h written=%b code=%h, %s",
                        w.read_byte, w.pixel_written, w.color_code,
                        $sformatf("actual read_byte=%h written=%b code=%h", rb, pw, cc));
            mismatches++;
         end
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic                                  req_kind;
   logic signed [pqnf_pkg::COORD_W-1:0]   req_pos_x;
   logic signed [pqnf_pkg::COORD_W-1:0]   req_pos_y;
   logic [pqnf_pkg::COMP_W-1:0]           req_red;
   logic [pqnf_pkg::COMP_W-1:0]           req_green;
   logic [pqnf_pkg::COMP_W-1:0]           req_blue;
   logic [pqnf_pkg::BADDR_W-1:0]          req_byte_addr;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic [7:0]                            rsp_read_byte;
   logic                                  rsp_pixel_written;
   logic [pqnf_pkg::CODE_W-1:0]           rsp_color_code;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [pqnf_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [pqnf_pkg::CSR_DATA_W-1:0]       csr_wdata;

   palette_scoreboard sb;
   bit                quiet;
   bit                long_hold_req;
   int                hold_left;
   int                burst_left;
   bit                hold_done;
   int                stalled_cycles;
   logic [7:0]        code_values [pqnf_pkg::NUM_COLORS];

   palette_quantize_nibble_framebuffer_top #(
      .PANEL_WIDTH  (PANEL_W),
      .PANEL_HEIGHT (PANEL_H)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_byte_addr     (req_byte_addr),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_pixel_written (rsp_pixel_written),
      .rsp_color_code    (rsp_color_code),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] rand_comp();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return $urandom_range(0, 1) ? 8'd127 : 8'd128;
         2: return 8'($urandom_range(0, 24));
         default: return 8'($urandom_range(231, 255));
      endcase
   endfunction

   function automatic int hot_coord(int span);
      return $urandom_range(0, 1) ? $urandom_range(0, 7) : span - 1 - $urandom_range(0, 7);
   endfunction

   task automatic send_word(input logic kind,
                            input logic signed [pqnf_pkg::COORD_W-1:0] x, y,
                            input logic [pqnf_pkg::COMP_W-1:0] r, g, b,
                            input logic [pqnf_pkg::BADDR_W-1:0] addr);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_red       <= r;
      req_green     <= g;
      req_blue      <= b;
      req_byte_addr <= addr;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_words(input int count);
      logic                                kind;
      logic signed [pqnf_pkg::COORD_W-1:0] x, y;
      logic [pqnf_pkg::COMP_W-1:0]         r, g, b;
      logic [pqnf_pkg::BADDR_W-1:0]        addr;
      int                                  pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         kind = KIND_DRAW;
         x    = CW'($urandom);
         y    = CW'($urandom);
         addr = BW'($urandom);
         r    = rand_comp();
         g    = rand_comp();
         b    = rand_comp();
         if ($urandom_range(0, 7) == 0) g = r;
         if (pick < 45) begin
            x = CW'(hot_coord(PANEL_W));
            y = CW'(hot_coord(PANEL_H));
         end else if (pick < 70) begin
            kind = KIND_READ;
            addr = BW'((hot_coord(PANEL_H) * PANEL_W + hot_coord(PANEL_W)) / 2);
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0: x = CW'(-$urandom_range(1, 2048));
               1: x = CW'($urandom_range(PANEL_W, 2047));
               2: y = CW'(-$urandom_range(1, 2048));
               default: y = CW'($urandom_range(PANEL_H, 2047));
            endcase
         end else if (pick < 90) begin
            kind = KIND_READ;
         end else begin
            kind = 1'($urandom_range(0, 1));
         end
         send_word(kind, x, y, r, g, b, addr);
      end
   endtask

   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_code(input logic [pqnf_pkg::CSR_IDX_W-1:0] idx,
                             input logic [pqnf_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   task automatic program_codes(input logic [7:0] values [pqnf_pkg::NUM_COLORS]);
      foreach (CODE_REGS[i]) write_code(CODE_REGS[i], values[i]);
   endtask

   always @(negedge clock) begin
      if (long_hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_word(rsp_read_byte, rsp_pixel_written, rsp_color_code);
         if (req_valid && req_ready)
            sb.note_word(req_kind, req_pos_x, req_pos_y, req_red, req_green, req_blue,
                         req_byte_addr);
         if (csr_valid && csr_ready)
            sb.set_code(csr_index, csr_wdata);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_DRAW;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_red        = '0;
      req_green      = '0;
      req_blue       = '0;
      req_byte_addr  = '0;
      rsp_ready      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = pqnf_pkg::CSR_CODE_BLACK;
      csr_wdata      = '0;
      quiet          = 1'b0;
      long_hold_req  = 1'b0;
      hold_left      = 0;
      burst_left     = 0;
      hold_done      = 1'b0;
      stalled_cycles = 0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_word(KIND_DRAW, 0, 0, 8'd0, 8'd0, 8'd0, '0);
      send_word(KIND_DRAW, 1, 0, 8'd255, 8'd255, 8'd255, '0);
      send_word(KIND_READ, 0, 0, 8'd0, 8'd0, 8'd0, 20'd0);
      send_word(KIND_DRAW, CW'(PANEL_W - 1), CW'(PANEL_H - 1), 8'd255, 8'd255, 8'd0, '1);
      send_word(KIND_DRAW, CW'(PANEL_W - 2), CW'(PANEL_H - 1), 8'd255, 8'd0, 8'd0, '1);
      send_word(KIND_READ, -1, -1, 8'd255, 8'd255, 8'd255, BW'(FRAME_BYTES - 1));
      send_word(KIND_DRAW, 2, 0, 8'd0, 8'd0, 8'd255, '0);
      send_word(KIND_DRAW, 3, 0, 8'd0, 8'd255, 8'd0, '0);
      send_word(KIND_READ, 0, 0, 8'd0, 8'd0, 8'd0, 20'd1);
      send_word(KIND_DRAW, -1, 5, 8'd0, 8'd0, 8'd255, '0);
      send_word(KIND_DRAW, 5, -1, 8'd255, 8'd0, 8'd0, '0);
      send_word(KIND_DRAW, CW'(PANEL_W), 0, 8'd0, 8'd255, 8'd0, '0);
      send_word(KIND_DRAW, 0, CW'(PANEL_H), 8'd255, 8'd255, 8'd0, '0);
      send_word(KIND_DRAW, -2048, -2048, 8'd255, 8'd255, 8'd255, '1);
      send_word(KIND_DRAW, 2047, 2047, 8'd0, 8'd255, 8'd0, '1);
      send_word(KIND_READ, 0, 0, 8'd0, 8'd0, 8'd0, BW'(FRAME_BYTES));
      send_word(KIND_READ, 2047, -2048, 8'd255, 8'd0, 8'd255, '1);
      send_word(KIND_READ, 0, 0, 8'd0, 8'd0, 8'd0, 20'd123456);
      send_word(KIND_DRAW, 4, 0, 8'd127, 8'd127, 8'd127, '0);
      send_word(KIND_DRAW, 5, 0, 8'd128, 8'd128, 8'd128, '0);
      send_word(KIND_DRAW, 6, 0, 8'd100, 8'd100, 8'd0, '0);
      send_word(KIND_DRAW, 7, 0, 8'd200, 8'd200, 8'd128, '0);
      send_word(KIND_READ, 0, 0, 8'd0, 8'd0, 8'd0, 20'd2);
      send_word(KIND_READ, 0, 0, 8'd0, 8'd0, 8'd0, 20'd3);
      send_word(KIND_DRAW, 0, 0, 8'd20, 8'd240, 8'd10, '0);
      send_word(KIND_READ, 0, 0, 8'd0, 8'd0, 8'd0, 20'd0);
      send_random_words(400);
      settle();

      code_values = '{default: 8'hFF};
      program_codes(code_values);
      write_code(pqnf_pkg::CSR_IDX_LIMIT, 8'h07);
      write_code(pqnf_pkg::CSR_IDX_LIMIT + 3'd1, 8'h0A);
      @(posedge clock);
      long_hold_req = 1'b1;
      send_random_words(350);
      settle();

      code_values = '{default: 8'hF0};
      program_codes(code_values);
      send_random_words(300);
      settle();

      foreach (code_values[i]) code_values[i] = 8'($urandom_range(0, 255));
      program_codes(code_values);
      send_random_words(400);
      settle();

      foreach (code_values[i]) code_values[i] = 8'($urandom_range(0, 255));
      program_codes(code_values);
      @(posedge clock);
      quiet = 1'b1;
      send_random_words(280);
      settle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
